>>> rtl/ddc_pkg.sv
package ddc_pkg;

   localparam int SIDES       = 2;
   localparam int SIDE_BYTES  = 65536;
   localparam int STORE_SIZE  = SIDES * SIDE_BYTES;
   localparam int ADDR_W      = $clog2(STORE_SIZE);
   localparam int SIDE_STRIDE = 65500;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [7:0]         NO_DISK       = 8'hFF;
   localparam logic [15:0]        PTR_LAST      = 16'd64999;
   localparam logic signed [8:0]  READ_WAIT     = 9'sd100;
   localparam logic signed [8:0]  CTRL_WAIT     = 9'sd200;
   localparam logic signed [9:0]  COUNTDOWN_MIN = -10'sd256;
   localparam logic signed [9:0]  DISK_STEP     = 10'sd114;
   localparam logic signed [17:0] TIMER_STEP    = 18'sd114;
   localparam logic [7:0]         STATUS_RESET  = 8'h80;
   localparam logic [7:0]         DRIVE_BASE    = 8'h40;
   localparam logic [7:0]         BATTERY_OK    = 8'h80;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_LOAD  = 2'd3
   } mode_type;

   localparam logic [4:0] REG_TIMER_LO   = 5'h00;
   localparam logic [4:0] REG_TIMER_HI   = 5'h01;
   localparam logic [4:0] REG_TIMER_CTRL = 5'h02;
   localparam logic [4:0] REG_ENABLE     = 5'h03;
   localparam logic [4:0] REG_WRITE_DATA = 5'h04;
   localparam logic [4:0] REG_CONTROL    = 5'h05;
   localparam logic [4:0] REG_STATUS     = 5'h10;
   localparam logic [4:0] REG_READ_DATA  = 5'h11;
   localparam logic [4:0] REG_DRIVE      = 5'h12;
   localparam logic [4:0] REG_BATTERY    = 5'h13;

   typedef struct packed {
      mode_type          mode;
      logic [4:0]        reg_offset;
      logic [7:0]        write_data;
      logic [16:0]       image_addr;
   } req_item_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              from_mem;
      logic              timer_irq;
      logic              disk_irq;
      logic              mirror_horizontal;
      logic [1:0]        drive_activity;
   } core_rsp_type;

   function automatic logic [ADDR_W-1:0] store_index(logic [7:0] side, logic [15:0] ptr);
      logic [24:0] full;
      full = 25'(side) * 25'(SIDE_STRIDE) + 25'(ptr);
      return full[ADDR_W-1:0];
   endfunction

endpackage

>>> rtl/ddc_ram.sv
module ddc_ram #(
   parameter int ADDR_W = 17,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ddc_core.sv
module ddc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ddc_pkg::req_item_type item,
   input  logic [7:0]            side,
   output ddc_pkg::mem_req_type  mem_req,
   output ddc_pkg::core_rsp_type rsp
);

   import ddc_pkg::*;

   logic [7:0]         status_ff, status_in;
   logic [7:0]         control_ff, control_in;
   logic [7:0]         enable_ff, enable_in;
   logic               mirror_ff, mirror_in;
   logic [1:0]         skip_ff, skip_in;
   logic signed [8:0]  countdown_ff, countdown_in;
   logic [15:0]        pointer_ff, pointer_in;
   logic [15:0]        reload_ff, reload_in;
   logic signed [16:0] count_ff, count_in;
   logic [1:0]         tmode_ff, tmode_in;
   logic [1:0]         activity_ff, activity_in;

   logic               no_disk;
   logic signed [17:0] tdiff;
   logic signed [9:0]  ddiff;
   logic signed [9:0]  dsat;

   assign no_disk = (side == NO_DISK);
   assign tdiff   = 18'(count_ff) - TIMER_STEP;
   assign ddiff   = 10'(countdown_ff) - DISK_STEP;
   assign dsat    = (ddiff < COUNTDOWN_MIN) ? COUNTDOWN_MIN : ddiff;

   always_comb begin
      status_in    = status_ff;
      control_in   = control_ff;
      enable_in    = enable_ff;
      mirror_in    = mirror_ff;
      skip_in      = skip_ff;
      countdown_in = countdown_ff;
      pointer_in   = pointer_ff;
      reload_in    = reload_ff;
      count_in     = count_ff;
      tmode_in     = tmode_ff;
      activity_in  = activity_ff;
      mem_req      = '0;
      rsp          = '0;

      case (item.mode)
         MODE_READ: begin
            case (item.reg_offset)
               REG_STATUS: begin
                  rsp.read_data = status_ff;
                  status_in     = status_ff & 8'hFC;
               end
               REG_READ_DATA: begin
                  if (!no_disk) begin
                     mem_req.en     = 1'b1;
                     mem_req.addr   = store_index(side, pointer_ff);
                     rsp.from_mem   = 1'b1;
                     activity_in[0] = 1'b1;
                     if (pointer_ff < PTR_LAST) begin
                        pointer_in = pointer_ff + 16'd1;
                     end
                     countdown_in = READ_WAIT;
                     status_in    = status_ff & 8'hFD;
                  end
               end
               REG_DRIVE: begin
                  rsp.read_data = DRIVE_BASE;
                  if (no_disk) begin
                     rsp.read_data[0] = 1'b1;
                     rsp.read_data[2] = 1'b1;
                  end
                  if (no_disk || !control_ff[0] || control_ff[1]) begin
                     rsp.read_data[1] = 1'b1;
                  end
               end
               REG_BATTERY: begin
                  rsp.read_data = BATTERY_OK;
               end
               default: begin
                  rsp.read_data = '0;
               end
            endcase
         end
         MODE_WRITE: begin
            case (item.reg_offset)
               REG_TIMER_LO: begin
                  reload_in[7:0] = item.write_data;
                  status_in[0]   = 1'b0;
               end
               REG_TIMER_HI: begin
                  reload_in[15:8] = item.write_data;
                  status_in[0]    = 1'b0;
               end
               REG_TIMER_CTRL: begin
                  tmode_in     = item.write_data[1:0];
                  count_in     = 17'(reload_ff);
                  status_in[0] = 1'b0;
               end
               REG_ENABLE: begin
                  enable_in = item.write_data;
               end
               REG_WRITE_DATA: begin
                  if (!no_disk && !control_ff[2] && enable_ff[0]) begin
                     if (skip_ff != 2'd0) begin
                        skip_in = skip_ff - 2'd1;
                     end else if (pointer_ff >= 16'd2) begin
                        mem_req.en     = 1'b1;
                        mem_req.we     = 1'b1;
                        mem_req.addr   = store_index(side, pointer_ff - 16'd2);
                        mem_req.wdata  = item.write_data;
                        activity_in[1] = 1'b1;
                     end
                  end
               end
               REG_CONTROL: begin
                  status_in[1] = 1'b0;
                  mirror_in    = item.write_data[3];
                  if (!no_disk) begin
                     if (!item.write_data[6] && control_ff[6] && !item.write_data[4]) begin
                        countdown_in = CTRL_WAIT;
                        pointer_in   = (pointer_ff >= 16'd2) ? pointer_ff - 16'd2 : 16'd0;
                     end
                     if (!item.write_data[2]) begin
                        skip_in = 2'd2;
                     end
                     if (item.write_data[1]) begin
                        pointer_in   = '0;
                        countdown_in = CTRL_WAIT;
                     end
                     if (item.write_data[6]) begin
                        countdown_in = CTRL_WAIT;
                     end
                     control_in = item.write_data;
                  end
               end
               default: begin
                  status_in = status_ff;
               end
            endcase
         end
         MODE_TICK: begin
            if (tmode_ff[1] && count_ff != 17'sd0) begin
               count_in = tdiff[16:0];
               if (tdiff <= 18'sd0) begin
                  if (tmode_ff[0]) begin
                     count_in = 17'(reload_ff);
                  end else begin
                     tmode_in[1] = 1'b0;
                  end
                  status_in[0]  = 1'b1;
                  rsp.timer_irq = 1'b1;
               end
            end
            if (countdown_ff != 9'sd0) begin
               countdown_in = dsat[8:0];
               if (dsat <= 10'sd0 && control_ff[7]) begin
                  status_in[1] = 1'b1;
                  rsp.disk_irq = 1'b1;
               end
            end
         end
         MODE_LOAD: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = item.image_addr[ADDR_W-1:0];
            mem_req.wdata = item.write_data;
         end
         default: begin
            mem_req = '0;
         end
      endcase

      rsp.mirror_horizontal = mirror_in;
      rsp.drive_activity    = activity_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= STATUS_RESET;
         control_ff   <= '0;
         enable_ff    <= '0;
         mirror_ff    <= 1'b0;
         skip_ff      <= '0;
         countdown_ff <= '0;
         pointer_ff   <= '0;
         reload_ff    <= '0;
         count_ff     <= '0;
         tmode_ff     <= '0;
         activity_ff  <= '0;
      end else if (step) begin
         status_ff    <= status_in;
         control_ff   <= control_in;
         enable_ff    <= enable_in;
         mirror_ff    <= mirror_in;
         skip_ff      <= skip_in;
         countdown_ff <= countdown_in;
         pointer_ff   <= pointer_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         tmode_ff     <= tmode_in;
         activity_ff  <= activity_in;
      end
   end

endmodule

>>> rtl/disk_drive_controller_registers.sv
// Words pass from the input register to the result register, which drives
// rsp_tvalid. Throughput: one word per cycle while rsp_tready holds; the
// two registers each advance whenever the next stage is free, and the disk
// store takes at most one access per word on its single port. Reset:
// synchronous, active high; resets both stage valids, the inserted side and
// all controller registers, status to 8'h80. The disk store is not cleared.
module disk_drive_controller_registers (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mode[1:0], reg_offset[6:2], write_data[14:7], image_addr[31:15]
   input  logic [ddc_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data[7:0], timer_irq[8], disk_irq[9], mirror_horizontal[10],
   // drive_activity[12:11], zero[15:13]
   output logic [ddc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [7:0]                      csr_wr_data
);

   import ddc_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   core_rsp_type  rsp_ff;
   logic [7:0]    side_ff, side_in;

   logic          advance;
   logic          req_take;
   mem_req_type   mem_req;
   core_rsp_type  core_rsp;
   logic [7:0]    ram_rdata;
   logic [7:0]    read_byte;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_item_in.mode       = mode_type'(req_tdata[1:0]);
   assign s1_item_in.reg_offset = req_tdata[6:2];
   assign s1_item_in.write_data = req_tdata[14:7];
   assign s1_item_in.image_addr = req_tdata[31:15];

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign side_in      = csr_wr_en ? csr_wr_data : side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         side_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   ddc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (s1_item_ff),
      .side    (side_ff),
      .mem_req (mem_req),
      .rsp     (core_rsp)
   );

   ddc_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (8)
   ) u_ram (
      .clock (clock),
      .en    (advance && mem_req.en),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (ram_rdata)
   );

   assign read_byte  = rsp_ff.from_mem ? ram_rdata : rsp_ff.read_data;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.drive_activity, rsp_ff.mirror_horizontal,
                        rsp_ff.disk_irq, rsp_ff.timer_irq, read_byte};

endmodule

>>> rtl/ddc_checker.sv
module ddc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8] || rsp_tdata[9]) |-> rsp_tdata[7:0] == 8'h00)
      else $error("interrupt word carries read data");

endmodule

bind disk_drive_controller_registers ddc_checker u_ddc_checker (.*);

>>> bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ddc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 36;
   localparam int PHASE_WORDS = 120;

   typedef struct packed {
      logic [16:0] image_addr;
      logic [7:0]  write_data;
      logic [4:0]  reg_offset;
      mode_type    mode;
   } bus_word_type;

   // same bit order as rsp_tdata
   typedef struct packed {
      logic [2:0] pad;
      logic [1:0] drive_activity;
      logic       mirror_horizontal;
      logic       disk_irq;
      logic       timer_irq;
      logic [7:0] read_data;
   } rsp_word_type;

   typedef struct {
      bus_word_type word;
      bit           typed;
      rsp_word_type want;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [7:0]             csr_wr_data;

   disk_drive_controller_registers u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // controller state as the bench sees it
   logic [7:0]  disk_mem [STORE_SIZE];
   bit          written [STORE_SIZE];
   logic [7:0]  cur_side;
   logic [7:0]  status_q;
   logic [7:0]  control_q;
   logic [7:0]  enable_q;
   logic        mirror_q;
   logic [1:0]  skip_left;
   int          disk_wait;
   logic [15:0] disk_ptr;
   logic [15:0] reload_val;
   int          timer_left;
   logic [1:0]  timer_ctl;
   logic [1:0]  activity_q;

   rsp_word_type due_rsp [$];
   plan_row_type plan [$];
   int           errors;
   int           cycles;
   bit           calm;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [16:0] disk_index(int ptr);
      return 17'((int'(cur_side) * SIDE_STRIDE + ptr) % STORE_SIZE);
   endfunction

   function automatic rsp_word_type drive_response(bus_word_type w);
      rsp_word_type r;
      logic [16:0]  idx;
      logic [7:0]   d;
      r = '0;
      d = w.write_data;
      case (w.mode)
         MODE_READ: begin
            case (w.reg_offset)
               REG_STATUS: begin
                  r.read_data = status_q;
                  status_q[1:0] = 2'b00;
               end
               REG_READ_DATA: begin
                  if (cur_side != NO_DISK) begin
                     idx = disk_index(int'(disk_ptr));
                     r.read_data = disk_mem[idx];
                     activity_q[0] = 1'b1;
                     if (disk_ptr < PTR_LAST) disk_ptr = disk_ptr + 16'd1;
                     disk_wait = int'(READ_WAIT);
                     status_q[1] = 1'b0;
                  end
               end
               REG_DRIVE: begin
                  r.read_data = DRIVE_BASE;
                  if (cur_side == NO_DISK) r.read_data |= 8'h05;
                  if (cur_side == NO_DISK || !control_q[0] || control_q[1])
                     r.read_data |= 8'h02;
               end
               REG_BATTERY: r.read_data = BATTERY_OK;
               default: r.read_data = 8'h00;
            endcase
         end
         MODE_WRITE: begin
            case (w.reg_offset)
               REG_TIMER_LO: begin
                  reload_val[7:0] = d;
                  status_q[0] = 1'b0;
               end
               REG_TIMER_HI: begin
                  reload_val[15:8] = d;
                  status_q[0] = 1'b0;
               end
               REG_TIMER_CTRL: begin
                  timer_ctl = d[1:0];
                  timer_left = int'(reload_val);
                  status_q[0] = 1'b0;
               end
               REG_ENABLE: enable_q = d;
               REG_WRITE_DATA: begin
                  if (cur_side != NO_DISK && !control_q[2] && enable_q[0]) begin
                     if (skip_left != 2'd0) begin
                        skip_left = skip_left - 2'd1;
                     end else if (disk_ptr >= 16'd2) begin
                        idx = disk_index(int'(disk_ptr) - 2);
                        disk_mem[idx] = d;
                        written[idx] = 1'b1;
                        activity_q[1] = 1'b1;
                     end
                  end
               end
               REG_CONTROL: begin
                  status_q[1] = 1'b0;
                  mirror_q = d[3];
                  if (cur_side != NO_DISK) begin
                     if (!d[6] && control_q[6] && !d[4]) begin
                        disk_wait = int'(CTRL_WAIT);
                        disk_ptr = (disk_ptr >= 16'd2) ? disk_ptr - 16'd2 : 16'd0;
                     end
                     if (!d[2]) skip_left = 2'd2;
                     if (d[1]) begin
                        disk_ptr = 16'd0;
                        disk_wait = int'(CTRL_WAIT);
                     end
                     if (d[6]) disk_wait = int'(CTRL_WAIT);
                     control_q = d;
                  end
               end
               default: ;
            endcase
         end
         MODE_TICK: begin
            if (timer_ctl[1] && timer_left != 0) begin
               timer_left -= int'(TIMER_STEP);
               if (timer_left <= 0) begin
                  if (timer_ctl[0]) timer_left = int'(reload_val);
                  else timer_ctl[1] = 1'b0;
                  status_q[0] = 1'b1;
                  r.timer_irq = 1'b1;
               end
            end
            if (disk_wait != 0) begin
               disk_wait -= int'(DISK_STEP);
               if (disk_wait < int'(COUNTDOWN_MIN)) disk_wait = int'(COUNTDOWN_MIN);
               if (disk_wait <= 0 && control_q[7]) begin
                  status_q[1] = 1'b1;
                  r.disk_irq = 1'b1;
               end
            end
         end
         default: begin
            disk_mem[w.image_addr] = d;
            written[w.image_addr] = 1'b1;
         end
      endcase
      r.mirror_horizontal = mirror_q;
      r.drive_activity = activity_q;
      return r;
   endfunction

   function automatic bus_word_type rand_word();
      bus_word_type w;
      int           pick;
      w.mode       = mode_type'(2'($urandom_range(3)));
      w.reg_offset = 5'($urandom_range(31));
      w.write_data = 8'($urandom);
      w.image_addr = 17'($urandom);
      pick = $urandom_range(99);
      if (pick < 14) begin
         w.mode = MODE_LOAD;
         if ($urandom_range(3) != 0)
            w.image_addr = disk_index(int'(disk_ptr) + $urandom_range(3));
      end else if (pick < 32) begin
         w.mode = MODE_READ;
         w.reg_offset = REG_READ_DATA;
      end else if (pick < 45) begin
         w.mode = MODE_WRITE;
         w.reg_offset = REG_WRITE_DATA;
      end else if (pick < 65) begin
         w.mode = MODE_TICK;
      end else if (pick < 72) begin
         w.mode = MODE_WRITE;
         w.reg_offset = REG_CONTROL;
         if ($urandom_range(1) != 0) w.write_data[2] = 1'b0;
         if ($urandom_range(9) < 6) w.write_data[7] = 1'b1;
         if ($urandom_range(1) != 0) w.write_data[1] = 1'b0;
      end else if (pick < 76) begin
         w.mode = MODE_WRITE;
         w.reg_offset = REG_ENABLE;
         w.write_data[0] = ($urandom_range(3) != 0);
      end else if (pick < 83) begin
         w.mode = MODE_WRITE;
         w.reg_offset = 5'($urandom_range(int'(REG_TIMER_CTRL)));
         if (w.reg_offset == REG_TIMER_HI && $urandom_range(3) != 0)
            w.write_data = 8'($urandom_range(2));
      end else if (pick < 93) begin
         w.mode = MODE_READ;
         w.reg_offset = REG_STATUS + 5'($urandom_range(3));
      end
      return w;
   endfunction

   task automatic send_word(bus_word_type w, bit typed, rsp_word_type typed_rsp);
      rsp_word_type r;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w.image_addr, w.write_data, w.reg_offset, w.mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = drive_response(w);
      due_rsp.push_back(typed ? typed_rsp : r);
   endtask

   // load the entry under the pointer first so a data read never hits an empty slot
   task automatic issue(bus_word_type w);
      bus_word_type fill;
      logic [16:0]  idx;
      idx = disk_index(int'(disk_ptr));
      if (w.mode == MODE_READ && w.reg_offset == REG_READ_DATA && cur_side != NO_DISK
          && !written[idx]) begin
         fill.mode       = MODE_LOAD;
         fill.reg_offset = 5'd0;
         fill.write_data = 8'($urandom);
         fill.image_addr = idx;
         send_word(fill, 1'b0, '0);
      end
      send_word(w, 1'b0, '0);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (due_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_side(logic [7:0] side);
      wait_drain();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= side;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_side = side;
   endtask

   task automatic run_phase(logic [7:0] side, bit quiet);
      set_side(side);
      calm = quiet;
      for (int k = 0; k < PHASE_WORDS; k++) begin
         // hold off until the pipe is empty
         if (k == PHASE_WORDS / 2) begin
            drop_valid();
            wait_drain();
         end
         issue(rand_word());
      end
      drop_valid();
      calm = 1'b0;
   endtask

   function automatic plan_row_type mk(mode_type m, logic [4:0] off, logic [7:0] d,
                                       logic [16:0] a, bit typed, logic [7:0] rd,
                                       logic [1:0] act);
      plan_row_type p;
      p.word.mode       = m;
      p.word.reg_offset = off;
      p.word.write_data = d;
      p.word.image_addr = a;
      p.typed           = typed;
      p.want            = '0;
      p.want.read_data  = rd;
      p.want.drive_activity = act;
      return p;
   endfunction

   always @(negedge clock) rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata);
         if (due_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            want = due_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: data %h/%h tirq %b/%b dirq %b/%b (exp/act)",
                           want.read_data, got.read_data, want.timer_irq, got.timer_irq,
                           want.disk_irq, got.disk_irq);
                  $display("  mirror %b/%b activity %b/%b pad %b/%b (exp/act)",
                           want.mirror_horizontal, got.mirror_horizontal,
                           want.drive_activity, got.drive_activity, want.pad, got.pad);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      reset       = 1'b1;
      calm        = 1'b0;
      errors      = 0;
      cycles      = 0;
      cur_side    = 8'h00;
      status_q    = STATUS_RESET;
      control_q   = 8'h00;
      enable_q    = 8'h00;
      mirror_q    = 1'b0;
      skip_left   = 2'd0;
      disk_wait   = 0;
      disk_ptr    = 16'd0;
      reload_val  = 16'd0;
      timer_left  = 0;
      timer_ctl   = 2'd0;
      activity_q  = 2'd0;

      plan.push_back(mk(MODE_READ,  REG_STATUS,     8'h00, 17'h00000, 1, 8'h80, 2'd0));
      plan.push_back(mk(MODE_READ,  REG_BATTERY,    8'h00, 17'h00000, 1, 8'h80, 2'd0));
      plan.push_back(mk(MODE_READ,  REG_DRIVE,      8'h00, 17'h00000, 1, 8'h42, 2'd0));
      plan.push_back(mk(MODE_READ,  5'h1F,          8'h00, 17'h00000, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, 5'h1F,          8'hFF, 17'h00000, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_LOAD,  5'h00,          8'hFF, 17'h1FFFF, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_LOAD,  5'h00,          8'hA5, 17'h00000, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_LOAD,  5'h00,          8'h5A, 17'h00001, 1, 8'h00, 2'd0));
      plan.push_back(mk(MODE_READ,  REG_READ_DATA,  8'h00, 17'h00000, 1, 8'hA5, 2'd1));
      plan.push_back(mk(MODE_READ,  REG_READ_DATA,  8'h00, 17'h00000, 1, 8'h5A, 2'd1));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_ENABLE,     8'h01, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_CONTROL,    8'h82, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_WRITE_DATA, 8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_WRITE_DATA, 8'hFF, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_READ,  REG_STATUS,     8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_TIMER_LO,   8'h64, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_TIMER_HI,   8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_TIMER_CTRL, 8'h02, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_TICK,  5'h00,          8'h00, 17'h00000, 0, 8'h00, 2'd0));
      plan.push_back(mk(MODE_WRITE, REG_CONTROL,    8'h48, 17'h00000, 0, 8'h00, 2'd0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);
      drop_valid();

      run_phase(8'd1, 1'b0);
      run_phase(NO_DISK, 1'b0);
      run_phase(8'd0, 1'b1);
      run_phase(8'd200, 1'b0);
      run_phase(8'($urandom_range(255)), 1'b0);

      wait_drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ddc_pkg.sv
rtl/ddc_ram.sv
rtl/ddc_core.sv
rtl/disk_drive_controller_registers.sv
rtl/ddc_checker.sv
bench/tb.sv
